// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define CC20_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define CC20_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cc20_pkg.sv =====
`default_nettype none

package cc20_pkg;

  localparam int unsigned DefaultRoundCount = 20;
  localparam int unsigned QueueDepth        = 2;
  localparam int unsigned CfgIdxW           = 3;
  localparam int unsigned CfgDataW          = 64;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    RegKeyLowPair    = 3'd0,
    RegKeySecondPair = 3'd1,
    RegKeyThirdPair  = 3'd2,
    RegKeyHighPair   = 3'd3,
    RegNonceLowPair  = 3'd4,
    RegNonceTopWord  = 3'd5,
    RegStartCounter  = 3'd6
  } cfg_reg_e;

  // "expand 32-byte k"
  localparam logic [3:0][31:0] Sigma = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  typedef struct packed {
    logic [7:0] plain;
    logic       start;
    logic [5:0] pos;
  } item_t;

  typedef struct packed {
    logic [7:0][31:0] key;
    logic [2:0][31:0] nonce;
    logic [31:0]      start_ctr;
  } cfg_t;

  // Block input words: constants, key, counter, nonce.
  function automatic logic [15:0][31:0] block_input(cfg_t cfg, logic [31:0] ctr);
    logic [15:0][31:0] w;
    w[3:0]   = Sigma;
    w[11:4]  = cfg.key;
    w[12]    = ctr;
    w[15:13] = cfg.nonce;
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cc20_queue.sv =====
`default_nettype none

module cc20_queue #(
  parameter int unsigned Depth = cc20_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cc20_pkg::item_t push_item_i,
  input  logic            pop_i,
  output cc20_pkg::item_t head_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  cc20_pkg::item_t       mem_q [Depth];
  logic [AW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]         cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cc20_front.sv =====
`default_nettype none

module cc20_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      plain_byte_i,
  input  logic            message_start_i,
  input  logic            q_full_i,
  output logic            push_o,
  output cc20_pkg::item_t push_item_o
);

  logic [5:0] pos_q, pos_d;
  logic [5:0] pos_cur;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Tag each word with its byte position; a message start restarts it.
  assign pos_cur = message_start_i ? 6'd0 : pos_q;
  assign pos_d   = push_o ? pos_cur + 6'd1 : pos_q;

  assign push_item_o.plain = plain_byte_i;
  assign push_item_o.start = message_start_i;
  assign push_item_o.pos   = pos_cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cc20_back.sv =====
`default_nettype none

module cc20_back #(
  parameter int unsigned ROUND_COUNT = cc20_pkg::DefaultRoundCount
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cc20_pkg::cfg_t  cfg_i,
  input  cc20_pkg::item_t head_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      cipher_byte_o
);

  localparam int unsigned Steps = ROUND_COUNT * 4;
  localparam int unsigned SW    = $clog2(Steps);

  localparam logic [1:0] QrAd16 = 2'd0;
  localparam logic [1:0] QrCb12 = 2'd1;
  localparam logic [1:0] QrAd8  = 2'd2;
  localparam logic [1:0] QrCb7  = 2'd3;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StRound = 3'b010,
    StFinal = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [SW-1:0]     step_q, step_d;
  logic [31:0]       ctr_q, ctr_d;
  logic              ready_q, ready_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic [15:0][31:0] x_q, x_d;
  logic [15:0][31:0] round_x;
  logic [15:0][31:0] init_w;
  logic [31:0]       ks_word;
  logic [7:0]        ks_byte;
  logic              out_free;
  logic              need_block;

  assign out_valid_o   = out_valid_q;
  assign cipher_byte_o = out_byte_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign need_block = (head_i.pos == 6'd0) && !ready_q;
  assign ks_word    = x_q[head_i.pos[5:2]];
  assign ks_byte    = ks_word[{head_i.pos[1:0], 3'b000} +: 8];
  assign init_w     = cc20_pkg::block_input(cfg_i, ctr_q);

  // One quarter-round step on all four lanes; bit 2 of the step picks
  // column or diagonal, the low bits pick the step within the quarter.
  always_comb begin : round_calc
    logic [1:0]  jb, jc, jd;
    logic [3:0]  ia, ib, ic, id;
    logic [31:0] a, b, c, d, s, v;
    round_x = x_q;
    for (int j = 0; j < 4; j++) begin
      if (step_q[2]) begin
        jb = 2'(j + 1);
        jc = 2'(j + 2);
        jd = 2'(j + 3);
      end else begin
        jb = 2'(j);
        jc = 2'(j);
        jd = 2'(j);
      end
      ia = {2'b00, 2'(j)};
      ib = {2'b01, jb};
      ic = {2'b10, jc};
      id = {2'b11, jd};
      a  = x_q[ia];
      b  = x_q[ib];
      c  = x_q[ic];
      d  = x_q[id];
      unique case (step_q[1:0])
        QrAd16: begin
          s = a + b;
          v = d ^ s;
          round_x[ia] = s;
          round_x[id] = {v[15:0], v[31:16]};
        end
        QrCb12: begin
          s = c + d;
          v = b ^ s;
          round_x[ic] = s;
          round_x[ib] = {v[19:0], v[31:20]};
        end
        QrAd8: begin
          s = a + b;
          v = d ^ s;
          round_x[ia] = s;
          round_x[id] = {v[23:0], v[31:24]};
        end
        QrCb7: begin
          s = c + d;
          v = b ^ s;
          round_x[ic] = s;
          round_x[ib] = {v[24:0], v[31:25]};
        end
        default: begin
          s = '0;
          v = '0;
        end
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    ctr_d       = ctr_q;
    ready_d     = ready_q;
    x_d         = x_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    unique case (state_q)
      StIdle: begin
        if (!empty_i && need_block) begin
          ctr_d   = head_i.start ? cfg_i.start_ctr : ctr_q;
          x_d     = cc20_pkg::block_input(cfg_i, ctr_d);
          step_d  = '0;
          state_d = StRound;
        end else if (!empty_i && out_free) begin
          pop_o       = 1'b1;
          out_valid_d = 1'b1;
          out_byte_d  = head_i.plain ^ ks_byte;
          ready_d     = 1'b0;
        end
      end
      StRound: begin
        x_d    = round_x;
        step_d = step_q + 1'b1;
        if (step_q == SW'(Steps - 1)) begin
          state_d = StFinal;
        end
      end
      StFinal: begin
        for (int i = 0; i < 16; i++) begin
          x_d[i] = x_q[i] + init_w[i];
        end
        ctr_d   = ctr_q + 32'd1;
        ready_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      ctr_q       <= 32'd1;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      ctr_q       <= ctr_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    out_byte_q <= out_byte_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/chacha20_stream_cipher_top.sv =====
// ChaCha20 byte stream cipher: each accepted word carries one byte and yields
// that byte XORed with the next keystream byte. A word at byte position zero
// (after reset, after every 64 bytes, or flagged message_start) first builds
// a fresh 64-byte keystream block in a shared quarter-round unit that does
// one add/xor/rotate step on all four lanes per cycle: the block is loaded,
// every step is run, the final add is done, and then the byte is emitted;
// the other 63 bytes of the block are emitted without a new build. A two-word
// queue sits between the input side and the keystream engine, and a registered
// output lets the next word be taken while a result still waits. Configuration
// is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must write it only
// while the block is idle, which the block itself does not enforce; the key and
// nonce are used at the next block built, start_counter at the next message start.
`default_nettype none

module chacha20_stream_cipher_top #(
  parameter int unsigned ROUND_COUNT = cc20_pkg::DefaultRoundCount
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cc20_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cc20_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    plain_byte_i,
  input  logic                          message_start_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    cipher_byte_o
);

  cc20_pkg::cfg_t  cfg_q, cfg_d;
  cc20_pkg::item_t push_item;
  cc20_pkg::item_t head;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;

  // Register file: drop writes to indexes past the list.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cc20_pkg::RegKeyLowPair:    cfg_d.key[1:0] = cfg_data_i;
        cc20_pkg::RegKeySecondPair: cfg_d.key[3:2] = cfg_data_i;
        cc20_pkg::RegKeyThirdPair:  cfg_d.key[5:4] = cfg_data_i;
        cc20_pkg::RegKeyHighPair:   cfg_d.key[7:6] = cfg_data_i;
        cc20_pkg::RegNonceLowPair:  cfg_d.nonce[1:0] = cfg_data_i;
        cc20_pkg::RegNonceTopWord:  cfg_d.nonce[2] = cfg_data_i[31:0];
        cc20_pkg::RegStartCounter:  cfg_d.start_ctr = cfg_data_i[31:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key       <= '0;
      cfg_q.nonce     <= '0;
      cfg_q.start_ctr <= 32'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: accept words and tag them with their byte position.
  cc20_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .plain_byte_i    (plain_byte_i),
    .message_start_i (message_start_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .push_item_o     (push_item)
  );

  // Hold tagged words while the engine builds a block.
  cc20_queue #(
    .Depth (cc20_pkg::QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // Back: build keystream blocks and emit the XORed bytes.
  cc20_back #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_i        (head),
    .empty_i       (q_empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cipher_byte_o (cipher_byte_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/cc20_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module cc20_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] cipher_byte_o
);

  localparam int unsigned CntW = $clog2(cc20_pkg::QueueDepth + 2);

  logic            in_acc;
  logic            out_acc;
  logic [CntW-1:0] open_q, open_d;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Track words taken in but not yet delivered.
  always_comb begin
    open_d = open_q;
    unique case ({in_acc, out_acc})
      2'b10:   open_d = open_q + 1'b1;
      2'b01:   open_d = open_q - 1'b1;
      default: open_d = open_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_d;
    end
  end

  `CC20_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "out valid dropped under stall")
  `CC20_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(cipher_byte_o), "out byte changed under stall")
  `CC20_ASSERT_IMP(a_no_invent, clk_i, rst_ni, out_valid_o, open_q != '0, "result with no word outstanding")
  `CC20_ASSERT_IMP(a_empty_ready, clk_i, rst_ni, open_q == '0, !in_stall_o, "input stalled with nothing outstanding")
  `CC20_ASSERT_IMP(a_bound, clk_i, rst_ni, 1'b1, open_q <= CntW'(cc20_pkg::QueueDepth + 1), "more words outstanding than storage")

endmodule

bind chacha20_stream_cipher_top cc20_checker u_cc20_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned Rounds    = 20;
  localparam int unsigned WordCount = 1650;  // words sent in total, directed part included
  localparam int unsigned QuietTail = 150;   // closing words sent with no idling on either side
  localparam int unsigned DrainWait = 200;   // extra wait after the final drain
  localparam longint unsigned CycleLimit = 1_000_000;

  // The port carries three index bits; the top code names no register.
  localparam logic [cc20_pkg::CfgIdxW-1:0] RegUnused = 3'd7;

  // Constant row, "expand 32-byte k" read as four little-endian words.
  localparam logic [3:0][31:0] ExpandK = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  // One line of the directed table: a register write, or a word to send.
  // Where typed is set, cipher holds the known answer and the predictor
  // output is not used as the expected value.
  typedef struct packed {
    logic                          is_cfg;
    logic [cc20_pkg::CfgIdxW-1:0]  idx;
    logic [cc20_pkg::CfgDataW-1:0] data;
    logic [7:0]                    plain;
    logic                          start;
    logic                          typed;
    logic [7:0]                    cipher;
  } script_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [cc20_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [cc20_pkg::CfgDataW-1:0] cfg_data_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [7:0]                    plain_byte_i;
  logic                          message_start_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [7:0]                    cipher_byte_o;

  // Predictor state: registers as last written, and the keystream position.
  logic [31:0]       key_w [8]   = '{default: 32'd0};
  logic [31:0]       nonce_w [3] = '{default: 32'd0};
  logic [31:0]       start_ctr   = 32'd1;
  logic [31:0]       block_ctr   = 32'd1;
  logic [15:0][31:0] keystream   = '0;
  logic [5:0]        byte_pos    = '0;

  logic [7:0]      pending_cipher [$];  // expected cipher bytes, oldest first
  logic [7:0]      expected_byte;
  script_row_t     script [$];
  bit              gaps_on    = 1'b1;   // random idling on both sides
  int unsigned     stall_left = 0;
  int unsigned     errors     = 0;
  int unsigned     words      = 0;
  int unsigned     blocks     = 0;
  int unsigned     wraps      = 0;
  int unsigned     reg_writes = 0;
  longint unsigned cycles     = 0;

  chacha20_stream_cipher_top #(
    .ROUND_COUNT(Rounds)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .plain_byte_i   (plain_byte_i),
    .message_start_i(message_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cipher_byte_o  (cipher_byte_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [31:0] rotl(logic [31:0] v, int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // Lanes come in as {d, c, b, a} with a in the low word.
  function automatic logic [3:0][31:0] quarter_round(logic [3:0][31:0] q);
    logic [31:0] a, b, c, d;
    {d, c, b, a} = q;
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    return {d, c, b, a};
  endfunction

  // Build one 64-byte keystream block for the given counter from the
  // current key and nonce.
  function automatic logic [15:0][31:0] keystream_block(logic [31:0] ctr);
    logic [15:0][31:0] init;
    logic [15:0][31:0] x;
    logic [3:0][31:0]  q;
    int unsigned       lane [4];
    init[3:0] = ExpandK;
    for (int i = 0; i < 8; i++) init[4 + i] = key_w[i];
    init[12] = ctr;
    for (int i = 0; i < 3; i++) init[13 + i] = nonce_w[i];
    x = init;
    for (int r = 0; r < Rounds; r++) begin
      for (int i = 0; i < 4; i++) begin
        // Even rounds work down the columns, odd rounds along the diagonals.
        for (int k = 0; k < 4; k++) lane[k] = 4 * k + ((r % 2 == 0) ? i : (i + k) % 4);
        for (int k = 0; k < 4; k++) q[k] = x[lane[k]];
        q = quarter_round(q);
        for (int k = 0; k < 4; k++) x[lane[k]] = q[k];
      end
    end
    for (int i = 0; i < 16; i++) x[i] = x[i] + init[i];
    return x;
  endfunction

  // Advance the predictor by one accepted word and return its cipher byte.
  function automatic logic [7:0] next_cipher_byte(logic [7:0] pb, logic st);
    logic [31:0] w;
    logic [7:0]  kb;
    if (st) begin
      block_ctr = start_ctr;
      byte_pos  = '0;
    end
    // Build a fresh block at position zero; the counter wraps at 32 bits.
    if (byte_pos == 6'd0) begin
      keystream = keystream_block(block_ctr);
      if (block_ctr == 32'hFFFF_FFFF) wraps++;
      block_ctr = block_ctr + 32'd1;
      blocks++;
    end
    w  = keystream[byte_pos[5:2]];
    kb = w[8 * byte_pos[1:0] +: 8];
    byte_pos = byte_pos + 6'd1;
    return pb ^ kb;
  endfunction

  function automatic logic [cc20_pkg::CfgDataW-1:0] pick_wide();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic script_row_t cfg_row(logic [cc20_pkg::CfgIdxW-1:0] idx,
                                          logic [cc20_pkg::CfgDataW-1:0] d);
    return {1'b1, idx, d, 8'h00, 1'b0, 1'b0, 8'h00};
  endfunction

  function automatic script_row_t word_row(logic [7:0] pb, logic st, logic typed,
                                           logic [7:0] cb);
    return {1'b0, cc20_pkg::RegKeyLowPair, 64'd0, pb, st, typed, cb};
  endfunction

  // Drive one register write for a cycle and mirror it in the predictor.
  // The caller drops the write enable once its batch is done.
  task automatic write_reg(logic [cc20_pkg::CfgIdxW-1:0] idx,
                           logic [cc20_pkg::CfgDataW-1:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    reg_writes++;
    // Bits above a register's width are dropped; an unknown index is ignored.
    case (idx)
      cc20_pkg::RegKeyLowPair, cc20_pkg::RegKeySecondPair,
      cc20_pkg::RegKeyThirdPair, cc20_pkg::RegKeyHighPair: begin
        key_w[2 * idx]     = d[31:0];
        key_w[2 * idx + 1] = d[63:32];
      end
      cc20_pkg::RegNonceLowPair: begin
        nonce_w[0] = d[31:0];
        nonce_w[1] = d[63:32];
      end
      cc20_pkg::RegNonceTopWord: nonce_w[2] = d[31:0];
      cc20_pkg::RegStartCounter: start_ctr = d[31:0];
      default: ;
    endcase
  endtask

  // Hold off new words until every expected byte has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_cipher.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Send one word, maybe after a short gap, and record its expected byte
  // once it is taken.
  task automatic send_word(logic [7:0] pb, logic st, logic typed, logic [7:0] typed_val);
    logic [7:0] predicted;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    plain_byte_i    <= pb;
    message_start_i <= st;
    do @(posedge clk_i); while (in_stall_o);
    predicted = next_cipher_byte(pb, st);
    pending_cipher.push_back(typed ? typed_val : predicted);
    words++;
  endtask

  // Check each taken output word against the oldest expected byte, and
  // stall the output side in short random bursts.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_cipher.size() == 0) begin
        $error("cipher_byte: expected none, actual %02h", cipher_byte_o);
        errors++;
      end else begin
        expected_byte = pending_cipher.pop_front();
        if (cipher_byte_o !== expected_byte) begin
          $error("cipher_byte: expected %02h, actual %02h", expected_byte, cipher_byte_o);
          errors++;
        end
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d bytes still owed", cycles, pending_cipher.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned msg_left;
    int unsigned phase;
    int unsigned next_cfg;
    bit          in_cfg;
    logic        st;
    logic [31:0] sc;

    msg_left = 0;
    phase    = 0;
    in_cfg   = 1'b0;

    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= cc20_pkg::RegKeyLowPair;
    cfg_data_i      <= '0;
    in_valid_i      <= 1'b0;
    plain_byte_i    <= 8'h00;
    message_start_i <= 1'b0;
    out_stall_i     <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. The first two words run on reset state with no
    // message start. Then load the well-known test key 00..1f with nonce
    // word 1 = 0x4a000000 and counter 1, and send "Ladies and Gentl",
    // whose cipher bytes are published. After that: a write to the unused
    // index, writes carrying junk above the register width (start counter
    // lands on all ones, so the next block wraps it), and a key change in
    // the middle of a block that must not touch the current block.
    script = '{
      word_row(8'h00, 1'b0, 1'b0, 8'h00),
      word_row(8'hFF, 1'b0, 1'b0, 8'h00),
      cfg_row(cc20_pkg::RegKeyLowPair,    64'h07060504_03020100),
      cfg_row(cc20_pkg::RegKeySecondPair, 64'h0f0e0d0c_0b0a0908),
      cfg_row(cc20_pkg::RegKeyThirdPair,  64'h17161514_13121110),
      cfg_row(cc20_pkg::RegKeyHighPair,   64'h1f1e1d1c_1b1a1918),
      cfg_row(cc20_pkg::RegNonceLowPair,  64'h4a000000_00000000),
      cfg_row(cc20_pkg::RegNonceTopWord,  64'h00000000_00000000),
      cfg_row(cc20_pkg::RegStartCounter,  64'h00000000_00000001),
      word_row(8'h4c, 1'b1, 1'b1, 8'h6e),
      word_row(8'h61, 1'b0, 1'b1, 8'h2e),
      word_row(8'h64, 1'b0, 1'b1, 8'h35),
      word_row(8'h69, 1'b0, 1'b1, 8'h9a),
      word_row(8'h65, 1'b0, 1'b1, 8'h25),
      word_row(8'h73, 1'b0, 1'b1, 8'h68),
      word_row(8'h20, 1'b0, 1'b1, 8'hf9),
      word_row(8'h61, 1'b0, 1'b1, 8'h80),
      word_row(8'h6e, 1'b0, 1'b1, 8'h41),
      word_row(8'h64, 1'b0, 1'b1, 8'hba),
      word_row(8'h20, 1'b0, 1'b1, 8'h07),
      word_row(8'h47, 1'b0, 1'b1, 8'h28),
      word_row(8'h65, 1'b0, 1'b1, 8'hdd),
      word_row(8'h6e, 1'b0, 1'b1, 8'h0d),
      word_row(8'h74, 1'b0, 1'b1, 8'h69),
      word_row(8'h6c, 1'b0, 1'b1, 8'h81),
      cfg_row(RegUnused,                  64'hFFFFFFFF_FFFFFFFF),
      cfg_row(cc20_pkg::RegNonceTopWord,  64'hFFFFFFFF_00000001),
      cfg_row(cc20_pkg::RegStartCounter,  64'h12345678_FFFFFFFF),
      word_row(8'hFF, 1'b1, 1'b0, 8'h00),
      word_row(8'h00, 1'b0, 1'b0, 8'h00),
      cfg_row(cc20_pkg::RegKeyLowPair,    64'hFFFFFFFF_FFFFFFFF),
      word_row(8'hA5, 1'b0, 1'b0, 8'h00),
      word_row(8'h5A, 1'b1, 1'b0, 8'h00)
    };

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        // Write only once the block has gone idle.
        if (!in_cfg) drain();
        in_cfg = 1'b1;
        write_reg(script[i].idx, script[i].data);
      end else begin
        if (in_cfg) cfg_we_i <= 1'b0;
        in_cfg = 1'b0;
        send_word(script[i].plain, script[i].start, script[i].typed, script[i].cipher);
      end
    end

    // Random part: messages of random length with random bytes, a stray
    // restart now and then, and a fresh register setting every couple of
    // hundred words. Messages run on across a setting change, so new keys
    // also land in the middle of a message.
    next_cfg = words + $urandom_range(100, 250);
    while (words < WordCount) begin
      if (words == next_cfg && words < WordCount - QuietTail) begin
        drain();
        for (int r = cc20_pkg::RegKeyLowPair; r <= cc20_pkg::RegNonceTopWord; r++) begin
          if ($urandom_range(0, 1) == 1) write_reg(cc20_pkg::CfgIdxW'(r), pick_wide());
        end
        // Rotate the start counter through its extremes and the wrap edge.
        case (phase % 4)
          0:       sc = 32'hFFFF_FFFF;
          1:       sc = $urandom;
          2:       sc = 32'h0000_0000;
          default: sc = 32'hFFFF_FFFE;
        endcase
        write_reg(cc20_pkg::RegStartCounter, {$urandom, sc});
        if ($urandom_range(0, 3) == 0) write_reg(RegUnused, {$urandom, $urandom});
        cfg_we_i <= 1'b0;
        phase++;
        next_cfg = words + $urandom_range(100, 250);
      end

      // Idle in stretches, and not at all near the end.
      if (words >= WordCount - QuietTail) gaps_on = 1'b0;
      else if ($urandom_range(0, 99) == 0) gaps_on = !gaps_on;

      if (msg_left == 0) begin
        msg_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom_range(60, 200);
        st = 1'b1;
      end else begin
        st = ($urandom_range(0, 49) == 0);
      end
      send_word(8'($urandom_range(0, 255)), st, 1'b0, 8'h00);
      msg_left--;
    end

    drain();
    repeat (DrainWait) @(posedge clk_i);

    $display("Covered %0d words over %0d keystream blocks with %0d counter wraps,",
             words, blocks, wraps);
    $display("and %0d register writes across %0d random settings.", reg_writes, phase);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
